/* rtl/rcsi_pkg.sv */
`default_nettype none

package rcsi_pkg;

    localparam int DATA_W        = 64;
    localparam int MAG_W         = 62;
    localparam int WORD_BITS     = 32;
    localparam int HH_W          = WORD_BITS - 2;
    localparam int DIST_W        = WORD_BITS - 1;
    localparam int QUEUE_DEPTH   = 4;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [DATA_W-1:0] t_q;

    // Internal values saturate symmetrically at +-(2^62 - 1).
    localparam t_q SAT_MAX = t_q'({2'b00, {MAG_W{1'b1}}});

    // Word handed from the front end to the back end through the queue.
    typedef struct packed {
        t_q                b;
        t_q                a2;
        t_q                d;
        t_q                oz;
        t_q                dz;
        logic [HH_W-1:0]   hh;
        logic [DIST_W-1:0] far_lim;
        logic              miss;
    } t_fq;

    function automatic t_q q_add(t_q x, t_q y);
        logic signed [DATA_W:0] s;
        logic signed [DATA_W:0] lim;
        lim = $signed({1'b0, SAT_MAX});
        s   = $signed({x[DATA_W-1], x}) + $signed({y[DATA_W-1], y});
        if (s > lim) begin
            return SAT_MAX;
        end else if (s < -lim) begin
            return -SAT_MAX;
        end
        return t_q'(s[DATA_W-1:0]);
    endfunction

    function automatic logic [MAG_W-1:0] q_mag(t_q x);
        t_q n;
        n = x[DATA_W-1] ? -x : x;
        return n[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/rcsi_mul.sv */
`default_nettype none

module rcsi_mul #(
    parameter int FRAC_BITS = rcsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_ce,
    input  wire rcsi_pkg::t_q i_x,
    input  wire rcsi_pkg::t_q i_y,
    output rcsi_pkg::t_q      o_p
);

    localparam int MW = rcsi_pkg::MAG_W;

    logic [63:0] ux, uy;
    logic [63:0] r_ll, r_lh, r_hl, r_hh;
    logic        r_neg;
    logic [127:0] full, sh;
    rcsi_pkg::t_q m;
    rcsi_pkg::t_q r_p;

    assign ux = {2'b00, rcsi_pkg::q_mag(i_x)};
    assign uy = {2'b00, rcsi_pkg::q_mag(i_y)};

    // First stage: four 32x32 partial products of the magnitudes.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ll  <= 64'(ux[31:0])  * 64'(uy[31:0]);
            r_lh  <= 64'(ux[31:0])  * 64'(uy[63:32]);
            r_hl  <= 64'(ux[63:32]) * 64'(uy[31:0]);
            r_hh  <= 64'(ux[63:32]) * 64'(uy[63:32]);
            r_neg <= i_x[63] ^ i_y[63];
        end
    end

    always_comb begin
        full = {r_hh, 64'd0} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0} + {64'd0, r_ll};
        sh   = full >> FRAC_BITS;
        m    = (|sh[127:MW]) ? rcsi_pkg::SAT_MAX : rcsi_pkg::t_q'(sh[MW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p <= r_neg ? -m : m;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* rtl/rcsi_div.sv */
`default_nettype none

module rcsi_div #(
    parameter int FRAC_BITS = rcsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_ce,
    input  wire rcsi_pkg::t_q i_num,
    input  wire rcsi_pkg::t_q i_den,
    output rcsi_pkg::t_q      o_quo
);

    localparam int MW = rcsi_pkg::MAG_W;
    localparam int NB = MW + FRAC_BITS;

    logic [NB-1:0] r_num [0:NB-1];
    logic [MW-1:0] r_den [0:NB-1];
    logic [MW-1:0] r_rem [0:NB-1];
    logic [MW-1:0] r_quo [0:NB];
    logic          r_sat [0:NB];
    logic          r_neg [0:NB];
    rcsi_pkg::t_q  mag_out;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_num[0] <= NB'(rcsi_pkg::q_mag(i_num)) << FRAC_BITS;
            r_den[0] <= rcsi_pkg::q_mag(i_den);
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_sat[0] <= 1'b0;
            r_neg[0] <= i_num[63] ^ i_den[63];
        end
    end

    // One quotient bit per stage, restoring division.
    for (genvar g = 0; g < NB; g++) begin : g_step
        logic [MW:0] shifted;
        logic [MW:0] diff;
        logic        ge;

        always_comb begin
            shifted = {r_rem[g], r_num[g][NB-1]};
            diff    = shifted - {1'b0, r_den[g]};
            ge      = shifted >= {1'b0, r_den[g]};
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_quo[g+1] <= {r_quo[g][MW-2:0], ge};
                // Once the quotient runs past the saturation limit it stays there.
                r_sat[g+1] <= r_sat[g] | r_quo[g][MW-1];
                r_neg[g+1] <= r_neg[g];
            end
        end

        if (g < NB - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_num[g+1] <= r_num[g] << 1;
                    r_den[g+1] <= r_den[g];
                    r_rem[g+1] <= ge ? diff[MW-1:0] : shifted[MW-1:0];
                end
            end
        end
    end

    assign mag_out = r_sat[NB] ? rcsi_pkg::SAT_MAX : rcsi_pkg::t_q'(r_quo[NB]);
    assign o_quo   = r_neg[NB] ? -mag_out : mag_out;

endmodule

`default_nettype wire

/* rtl/rcsi_sqrt.sv */
`default_nettype none

module rcsi_sqrt #(
    parameter int FRAC_BITS = rcsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_ce,
    input  wire rcsi_pkg::t_q i_x,
    output rcsi_pkg::t_q      o_root
);

    localparam int MW = rcsi_pkg::MAG_W;
    localparam int NB = MW + FRAC_BITS;
    localparam int NE = NB + (NB % 2);
    localparam int RB = NE / 2;

    logic [NE-1:0]   r_num  [0:RB-1];
    logic [RB+1:0]   r_rem  [0:RB-1];
    logic [RB-1:0]   r_root [0:RB];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_num[0]  <= NE'(i_x[MW-1:0]) << FRAC_BITS;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // One root bit per stage from two radicand bits.
    for (genvar g = 0; g < RB; g++) begin : g_step
        logic [RB+3:0] shifted;
        logic [RB+3:0] trial;
        logic [RB+3:0] diff;
        logic          ge;

        always_comb begin
            shifted = {r_rem[g], r_num[g][NE-1:NE-2]};
            trial   = {2'b00, r_root[g], 2'b01};
            diff    = shifted - trial;
            ge      = shifted >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_root[g+1] <= {r_root[g][RB-2:0], ge};
            end
        end

        if (g < RB - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_num[g+1] <= r_num[g] << 2;
                    r_rem[g+1] <= ge ? diff[RB+1:0] : shifted[RB+1:0];
                end
            end
        end
    end

    assign o_root = rcsi_pkg::t_q'(r_root[RB]);

endmodule

`default_nettype wire

/* rtl/rcsi_front.sv */
`default_nettype none

module rcsi_front #(
    parameter int FRAC_BITS = rcsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_origin_x,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_origin_y,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_origin_z,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_dir_x,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_dir_y,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_dir_z,
    input  wire logic [rcsi_pkg::DIST_W-1:0]          i_cone_radius,
    input  wire logic [rcsi_pkg::DIST_W-1:0]          i_cone_height,
    input  wire logic [rcsi_pkg::DIST_W-1:0]          i_far_limit,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output rcsi_pkg::t_fq                             o_data
);

    localparam int DIV_LAT = rcsi_pkg::MAG_W + FRAC_BITS + 1;
    localparam int MUL_LAT = 2;

    typedef rcsi_pkg::t_q t_q;
    typedef logic [rcsi_pkg::HH_W-1:0]   t_hh;
    typedef logic [rcsi_pkg::DIST_W-1:0] t_dist;

    typedef struct packed {
        t_q ox; t_q oy; t_q oz; t_q dx; t_q dy; t_q dz;
        t_hh hh; t_dist far_lim; logic hz;
    } t_fs1;
    typedef struct packed {
        t_q oz; t_q dz; t_hh hh; t_dist far_lim; logic hz;
    } t_fs2;
    typedef struct packed {
        t_q apre; t_q bh; t_q cpre; t_q oz; t_q dz; t_hh hh; t_dist far_lim; logic hz;
    } t_fs3;
    typedef struct packed {
        t_q a; t_q b; t_q c; t_q oz; t_q dz; t_hh hh; t_dist far_lim; logic hz;
    } t_fs4;
    typedef struct packed {
        t_q a2; t_q a4; t_q b; t_q c; t_q oz; t_q dz; t_hh hh; t_dist far_lim;
        logic hz; logic a_nz;
    } t_fs5;
    typedef struct packed {
        t_q a2; t_q b; t_q oz; t_q dz; t_hh hh; t_dist far_lim; logic hz; logic a_nz;
    } t_fs6;

    logic          ce;
    logic          r_s0_v;
    t_fs1          r_s0_side;
    t_dist         r_s0_rad;
    logic          r_s1_v    [0:DIV_LAT-1];
    t_fs1          r_s1_side [0:DIV_LAT-1];
    logic          r_s2_v    [0:MUL_LAT-1];
    t_fs2          r_s2_side [0:MUL_LAT-1];
    logic          r_s3_v    [0:MUL_LAT-1];
    t_fs3          r_s3_side [0:MUL_LAT-1];
    logic          r_s4_v;
    t_fs4          r_s4;
    logic          r_s5_v;
    t_fs5          r_s5;
    logic          r_s6_v    [0:MUL_LAT-1];
    t_fs6          r_s6_side [0:MUL_LAT-1];
    logic          r_s7_v;
    rcsi_pkg::t_fq r_s7_data;

    t_q   q, k;
    t_q   dxdx, dydy, dzdz, oxdx, oydy, ozdz, oxox, oyoy, ozoz;
    t_q   m1, m2, m3, bb, ac;
    t_fs1 s1;
    t_fs3 s3;
    t_fs6 s6;
    t_fs1 n_s0_side;
    t_fs3 n_s3_side;
    t_fs4 n_s4;
    t_fs5 n_s5;
    t_fs6 n_s6_side;
    rcsi_pkg::t_fq n_s7_data;
    t_q   d;

    // The whole front pipeline advances together; it holds only when its
    // last word cannot enter the queue.
    assign ce      = !r_s7_v || i_ready;
    assign o_ready = ce;
    assign o_valid = r_s7_v;
    assign o_data  = r_s7_data;

    always_comb begin
        n_s0_side.ox      = t_q'(i_origin_x);
        n_s0_side.oy      = t_q'(i_origin_y);
        n_s0_side.oz      = t_q'(i_origin_z);
        n_s0_side.dx      = t_q'(i_dir_x);
        n_s0_side.dy      = t_q'(i_dir_y);
        n_s0_side.dz      = t_q'(i_dir_z);
        n_s0_side.hh      = i_cone_height[rcsi_pkg::DIST_W-1:1];
        n_s0_side.far_lim = i_far_limit;
        n_s0_side.hz      = (i_cone_height[rcsi_pkg::DIST_W-1:1] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (ce) begin
            r_s0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s0_side <= n_s0_side;
            r_s0_rad  <= i_cone_radius;
        end
    end

    // Slope ratio r / hh; a zero half height is replaced by one and flagged.
    rcsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_q (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (t_q'(r_s0_rad)),
        .i_den (r_s0_side.hz ? t_q'(1) : t_q'(r_s0_side.hh)),
        .o_quo (q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_LAT; j++) begin
                r_s1_v[j] <= 1'b0;
            end
        end else if (ce) begin
            r_s1_v[0] <= r_s0_v;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_s1_v[j] <= r_s1_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1_side[0] <= r_s0_side;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_s1_side[j] <= r_s1_side[j-1];
            end
        end
    end

    assign s1 = r_s1_side[DIV_LAT-1];

    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k    (.i_clk(i_clk), .i_ce(ce), .i_x(q),     .i_y(q),     .o_p(k));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_dxdx (.i_clk(i_clk), .i_ce(ce), .i_x(s1.dx), .i_y(s1.dx), .o_p(dxdx));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_dydy (.i_clk(i_clk), .i_ce(ce), .i_x(s1.dy), .i_y(s1.dy), .o_p(dydy));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_dzdz (.i_clk(i_clk), .i_ce(ce), .i_x(s1.dz), .i_y(s1.dz), .o_p(dzdz));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_oxdx (.i_clk(i_clk), .i_ce(ce), .i_x(s1.ox), .i_y(s1.dx), .o_p(oxdx));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_oydy (.i_clk(i_clk), .i_ce(ce), .i_x(s1.oy), .i_y(s1.dy), .o_p(oydy));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ozdz (.i_clk(i_clk), .i_ce(ce), .i_x(s1.oz), .i_y(s1.dz), .o_p(ozdz));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_oxox (.i_clk(i_clk), .i_ce(ce), .i_x(s1.ox), .i_y(s1.ox), .o_p(oxox));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_oyoy (.i_clk(i_clk), .i_ce(ce), .i_x(s1.oy), .i_y(s1.oy), .o_p(oyoy));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ozoz (.i_clk(i_clk), .i_ce(ce), .i_x(s1.oz), .i_y(s1.oz), .o_p(ozoz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v[0] <= 1'b0;
            r_s2_v[1] <= 1'b0;
        end else if (ce) begin
            r_s2_v[0] <= r_s1_v[DIV_LAT-1];
            r_s2_v[1] <= r_s2_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s2_side[0] <= '{oz: s1.oz, dz: s1.dz, hh: s1.hh, far_lim: s1.far_lim, hz: s1.hz};
            r_s2_side[1] <= r_s2_side[0];
        end
    end

    always_comb begin
        n_s3_side.apre    = rcsi_pkg::q_add(dxdx, dydy);
        n_s3_side.bh      = rcsi_pkg::q_add(oxdx, oydy);
        n_s3_side.cpre    = rcsi_pkg::q_add(oxox, oyoy);
        n_s3_side.oz      = r_s2_side[1].oz;
        n_s3_side.dz      = r_s2_side[1].dz;
        n_s3_side.hh      = r_s2_side[1].hh;
        n_s3_side.far_lim = r_s2_side[1].far_lim;
        n_s3_side.hz      = r_s2_side[1].hz;
    end

    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_m1 (.i_clk(i_clk), .i_ce(ce), .i_x(dzdz), .i_y(k), .o_p(m1));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_m2 (.i_clk(i_clk), .i_ce(ce), .i_x(ozdz), .i_y(k), .o_p(m2));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_m3 (.i_clk(i_clk), .i_ce(ce), .i_x(ozoz), .i_y(k), .o_p(m3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v[0] <= 1'b0;
            r_s3_v[1] <= 1'b0;
        end else if (ce) begin
            r_s3_v[0] <= r_s2_v[1];
            r_s3_v[1] <= r_s3_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s3_side[0] <= n_s3_side;
            r_s3_side[1] <= r_s3_side[0];
        end
    end

    assign s3 = r_s3_side[1];

    always_comb begin
        n_s4.a       = rcsi_pkg::q_add(s3.apre, -m1);
        n_s4.b       = rcsi_pkg::q_add(rcsi_pkg::q_add(s3.bh, s3.bh), -rcsi_pkg::q_add(m2, m2));
        n_s4.c       = rcsi_pkg::q_add(s3.cpre, -m3);
        n_s4.oz      = s3.oz;
        n_s4.dz      = s3.dz;
        n_s4.hh      = s3.hh;
        n_s4.far_lim = s3.far_lim;
        n_s4.hz      = s3.hz;
    end

    always_comb begin
        n_s5.a2      = rcsi_pkg::q_add(r_s4.a, r_s4.a);
        n_s5.a4      = rcsi_pkg::q_add(n_s5.a2, n_s5.a2);
        n_s5.b       = r_s4.b;
        n_s5.c       = r_s4.c;
        n_s5.oz      = r_s4.oz;
        n_s5.dz      = r_s4.dz;
        n_s5.hh      = r_s4.hh;
        n_s5.far_lim = r_s4.far_lim;
        n_s5.hz      = r_s4.hz;
        n_s5.a_nz    = (r_s4.a != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (ce) begin
            r_s4_v <= r_s3_v[1];
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s4 <= n_s4;
            r_s5 <= n_s5;
        end
    end

    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_bb (.i_clk(i_clk), .i_ce(ce), .i_x(r_s5.b),  .i_y(r_s5.b), .o_p(bb));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ac (.i_clk(i_clk), .i_ce(ce), .i_x(r_s5.a4), .i_y(r_s5.c), .o_p(ac));

    always_comb begin
        n_s6_side.a2      = r_s5.a2;
        n_s6_side.b       = r_s5.b;
        n_s6_side.oz      = r_s5.oz;
        n_s6_side.dz      = r_s5.dz;
        n_s6_side.hh      = r_s5.hh;
        n_s6_side.far_lim = r_s5.far_lim;
        n_s6_side.hz      = r_s5.hz;
        n_s6_side.a_nz    = r_s5.a_nz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v[0] <= 1'b0;
            r_s6_v[1] <= 1'b0;
        end else if (ce) begin
            r_s6_v[0] <= r_s5_v;
            r_s6_v[1] <= r_s6_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s6_side[0] <= n_s6_side;
            r_s6_side[1] <= r_s6_side[0];
        end
    end

    assign s6 = r_s6_side[1];
    assign d  = rcsi_pkg::q_add(bb, -ac);

    // Rays that cannot hit are marked here and pass through the back end
    // untouched so that order is kept.
    always_comb begin
        n_s7_data.b       = s6.b;
        n_s7_data.a2      = s6.a2;
        n_s7_data.d       = d;
        n_s7_data.oz      = s6.oz;
        n_s7_data.dz      = s6.dz;
        n_s7_data.hh      = s6.hh;
        n_s7_data.far_lim = s6.far_lim;
        n_s7_data.miss    = s6.hz || !s6.a_nz || d[rcsi_pkg::DATA_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else if (ce) begin
            r_s7_v <= r_s6_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s7_data <= n_s7_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/rcsi_queue.sv */
`default_nettype none

module rcsi_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire rcsi_pkg::t_fq  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output rcsi_pkg::t_fq       o_data
);

    localparam int DEPTH = rcsi_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    rcsi_pkg::t_fq r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/rcsi_back.sv */
`default_nettype none

module rcsi_back #(
    parameter int FRAC_BITS = rcsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire rcsi_pkg::t_fq              i_data,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [rcsi_pkg::DIST_W-1:0]     o_hit_distance,
    output logic                            o_hit_found
);

    localparam int NB      = rcsi_pkg::MAG_W + FRAC_BITS;
    localparam int SQ_LAT  = (NB + (NB % 2)) / 2 + 1;
    localparam int DIV_LAT = NB + 1;
    localparam int MUL_LAT = 2;

    typedef rcsi_pkg::t_q t_q;
    typedef logic [rcsi_pkg::HH_W-1:0]   t_hh;
    typedef logic [rcsi_pkg::DIST_W-1:0] t_dist;

    typedef struct packed {
        t_q b; t_q a2; t_q oz; t_q dz; t_hh hh; t_dist far_lim; logic miss;
    } t_bs1;
    typedef struct packed {
        t_q n0; t_q n1; t_q a2; t_q oz; t_q dz; t_hh hh; t_dist far_lim; logic miss;
    } t_bs2;
    typedef struct packed {
        t_q oz; t_q dz; t_hh hh; t_dist far_lim; logic miss;
    } t_bs3;
    typedef struct packed {
        t_q t0; t_q t1; t_q oz; t_hh hh; t_dist far_lim; logic miss;
    } t_bs4;
    typedef struct packed {
        t_q z0; t_q z1; t_q t0; t_q t1; t_hh hh; t_dist far_lim; logic miss;
    } t_bs5;

    logic  ce;
    logic  r_s1_v    [0:SQ_LAT-1];
    t_bs1  r_s1_side [0:SQ_LAT-1];
    logic  r_s2_v;
    t_bs2  r_s2;
    logic  r_s3_v    [0:DIV_LAT-1];
    t_bs3  r_s3_side [0:DIV_LAT-1];
    logic  r_s4_v    [0:MUL_LAT-1];
    t_bs4  r_s4_side [0:MUL_LAT-1];
    logic  r_s5_v;
    t_bs5  r_s5;
    logic  r_out_v;
    t_dist r_dist;
    logic  r_found;

    t_q    s, t0, t1, m0, m1;
    t_bs1  s1;
    t_bs3  s3;
    t_bs4  s4;
    t_bs2  n_s2;
    t_bs5  n_s5;
    t_q    hh_q, best0, best1;
    logic  ok0, ok1, take0, take1;

    // The output register is the last back-end stage.
    assign ce             = !r_out_v || i_ready;
    assign o_ready        = ce;
    assign o_valid        = r_out_v;
    assign o_hit_distance = r_dist;
    assign o_hit_found    = r_found;

    rcsi_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_x    (i_data.d[rcsi_pkg::DATA_W-1] ? t_q'(0) : i_data.d),
        .o_root (s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SQ_LAT; j++) begin
                r_s1_v[j] <= 1'b0;
            end
        end else if (ce) begin
            r_s1_v[0] <= i_valid;
            for (int j = 1; j < SQ_LAT; j++) begin
                r_s1_v[j] <= r_s1_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1_side[0] <= '{b: i_data.b, a2: i_data.a2, oz: i_data.oz, dz: i_data.dz,
                              hh: i_data.hh, far_lim: i_data.far_lim, miss: i_data.miss};
            for (int j = 1; j < SQ_LAT; j++) begin
                r_s1_side[j] <= r_s1_side[j-1];
            end
        end
    end

    assign s1 = r_s1_side[SQ_LAT-1];

    // A tangent ray, where the root of the discriminant is zero, is a miss.
    always_comb begin
        n_s2.n0      = rcsi_pkg::q_add(-s1.b, s);
        n_s2.n1      = rcsi_pkg::q_add(-s1.b, -s);
        n_s2.a2      = s1.a2;
        n_s2.oz      = s1.oz;
        n_s2.dz      = s1.dz;
        n_s2.hh      = s1.hh;
        n_s2.far_lim = s1.far_lim;
        n_s2.miss    = s1.miss || (s == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (ce) begin
            r_s2_v <= r_s1_v[SQ_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s2 <= n_s2;
        end
    end

    rcsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_t0 (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_s2.n0),
        .i_den (r_s2.a2),
        .o_quo (t0)
    );

    rcsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_t1 (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (r_s2.n1),
        .i_den (r_s2.a2),
        .o_quo (t1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_LAT; j++) begin
                r_s3_v[j] <= 1'b0;
            end
        end else if (ce) begin
            r_s3_v[0] <= r_s2_v;
            for (int j = 1; j < DIV_LAT; j++) begin
                r_s3_v[j] <= r_s3_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s3_side[0] <= '{oz: r_s2.oz, dz: r_s2.dz, hh: r_s2.hh, far_lim: r_s2.far_lim,
                              miss: r_s2.miss};
            for (int j = 1; j < DIV_LAT; j++) begin
                r_s3_side[j] <= r_s3_side[j-1];
            end
        end
    end

    assign s3 = r_s3_side[DIV_LAT-1];

    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_z0 (.i_clk(i_clk), .i_ce(ce), .i_x(s3.dz), .i_y(t0), .o_p(m0));
    rcsi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_z1 (.i_clk(i_clk), .i_ce(ce), .i_x(s3.dz), .i_y(t1), .o_p(m1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v[0] <= 1'b0;
            r_s4_v[1] <= 1'b0;
        end else if (ce) begin
            r_s4_v[0] <= r_s3_v[DIV_LAT-1];
            r_s4_v[1] <= r_s4_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s4_side[0] <= '{t0: t0, t1: t1, oz: s3.oz, hh: s3.hh, far_lim: s3.far_lim,
                              miss: s3.miss};
            r_s4_side[1] <= r_s4_side[0];
        end
    end

    assign s4 = r_s4_side[1];

    always_comb begin
        n_s5.z0      = rcsi_pkg::q_add(s4.oz, m0);
        n_s5.z1      = rcsi_pkg::q_add(s4.oz, m1);
        n_s5.t0      = s4.t0;
        n_s5.t1      = s4.t1;
        n_s5.hh      = s4.hh;
        n_s5.far_lim = s4.far_lim;
        n_s5.miss    = s4.miss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (ce) begin
            r_s5_v <= r_s4_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s5 <= n_s5;
        end
    end

    // A root counts when it lies ahead of the origin and its point is on the
    // coat; the nearer one below the far limit wins, the first root on a tie.
    always_comb begin
        hh_q  = t_q'(r_s5.hh);
        ok0   = !r_s5.miss && !r_s5.t0[rcsi_pkg::DATA_W-1]
                && !r_s5.z0[rcsi_pkg::DATA_W-1] && (r_s5.z0 <= hh_q);
        ok1   = !r_s5.miss && !r_s5.t1[rcsi_pkg::DATA_W-1]
                && !r_s5.z1[rcsi_pkg::DATA_W-1] && (r_s5.z1 <= hh_q);
        take0 = ok0 && (r_s5.t0 < t_q'(r_s5.far_lim));
        best0 = take0 ? r_s5.t0 : t_q'(r_s5.far_lim);
        take1 = ok1 && (r_s5.t1 < best0);
        best1 = take1 ? r_s5.t1 : best0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ce) begin
            r_out_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dist  <= best1[rcsi_pkg::DIST_W-1:0];
            r_found <= take0 || take1;
        end
    end

endmodule

`default_nettype wire

/* rtl/ray_cone_surface_intersect_top.sv */
// Ray against cone coat, fully pipelined: one ray accepted per cycle, one result per cycle,
// unless a stall holds the pipeline. The front divider, the square root and the two root
// dividers, which run side by side, make up most of the pipeline depth.
// A four-word queue sits between the front end and the back end; each half stalls on its own.
// Reset (synchronous, active low) clears all valid bits, the queue pointers and count only.
`default_nettype none

module ray_cone_surface_intersect_top #(
    parameter int FRAC_BITS = rcsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_origin_x,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_origin_y,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_origin_z,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_dir_x,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_dir_y,
    input  wire logic signed [rcsi_pkg::WORD_BITS-1:0] i_dir_z,
    input  wire logic [rcsi_pkg::DIST_W-1:0]          i_cone_radius,
    input  wire logic [rcsi_pkg::DIST_W-1:0]          i_cone_height,
    input  wire logic [rcsi_pkg::DIST_W-1:0]          i_far_limit,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [rcsi_pkg::DIST_W-1:0]               o_hit_distance,
    output logic                                      o_hit_found
);

    logic          f_valid, f_ready;
    rcsi_pkg::t_fq f_data;
    logic          b_valid, b_ready;
    rcsi_pkg::t_fq b_data;

    rcsi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_origin_z    (i_origin_z),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_cone_radius (i_cone_radius),
        .i_cone_height (i_cone_height),
        .i_far_limit   (i_far_limit),
        .o_valid       (f_valid),
        .i_ready       (f_ready),
        .o_data        (f_data)
    );

    rcsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (b_data)
    );

    rcsi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (b_valid),
        .o_ready        (b_ready),
        .i_data         (b_data),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_hit_distance (o_hit_distance),
        .o_hit_found    (o_hit_found)
    );

endmodule

`default_nettype wire

/* bench/ray_cone_surface_intersect_top_test.sv */
`timescale 1ns / 1ps

module ray_cone_surface_intersect_top_test;

    localparam int     STALL_LIMIT = 5000;
    localparam int     DRAIN_WAIT  = 300;
    localparam int     HOLD_CYCLES = 800;
    localparam longint FX_MAX      = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
        logic [30:0]        rad, hgt, far;
    } ray_t;

    typedef struct {
        logic [30:0] distance;
        logic        found;
    } hit_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [31:0] i_dir_x, i_dir_y, i_dir_z;
    logic [30:0]        i_cone_radius, i_cone_height, i_far_limit;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [30:0]        o_hit_distance;
    logic               o_hit_found;

    hit_t hits_pending[$];
    int   fail_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_req;
    int   quiet_cycles;

    ray_cone_surface_intersect_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_origin_z    (i_origin_z),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_cone_radius (i_cone_radius),
        .i_cone_height (i_cone_height),
        .i_far_limit   (i_far_limit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit_distance(o_hit_distance),
        .o_hit_found   (o_hit_found)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Fixed-point helpers, 16 fraction bits, saturating at +-(2^62 - 1).
    function automatic longint fx_sat(longint x);
        if (x > FX_MAX) return FX_MAX;
        if (x < -FX_MAX) return -FX_MAX;
        return x;
    endfunction

    function automatic longint fx_add(longint x, longint y);
        return fx_sat(x + y);
    endfunction

    function automatic logic [127:0] fx_abs(longint x);
        logic [127:0] m;
        m = (x < 0) ? 128'(-x) : 128'(x);
        return m;
    endfunction

    function automatic longint fx_mul(longint x, longint y);
        logic [127:0] p;
        bit           neg;
        neg = (x < 0) != (y < 0);
        p   = (fx_abs(x) * fx_abs(y)) >> 16;
        if (p > 128'(FX_MAX)) p = 128'(FX_MAX);
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint fx_div(longint x, longint y);
        logic [127:0] q;
        bit           neg;
        neg = (x < 0) != (y < 0);
        q   = (fx_abs(x) << 16) / fx_abs(y);
        if (q > 128'(FX_MAX)) q = 128'(FX_MAX);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint fx_sqrt(longint x);
        logic [127:0] n;
        logic [127:0] root;
        logic [127:0] cand;
        n    = fx_abs(x) << 16;
        root = '0;
        for (int i = 62; i >= 0; i--) begin
            cand = root | (128'd1 << i);
            if (cand * cand <= n) root = cand;
        end
        return longint'(root[63:0]);
    endfunction

    function automatic bit on_coat(longint t, longint oz, longint dz, longint hh);
        longint z;
        if (t < 0) return 1'b0;
        z = fx_add(oz, fx_mul(dz, t));
        return z >= 0 && z <= hh;
    endfunction

    function automatic hit_t cone_hit(ray_t r);
        longint ox, oy, oz, dx, dy, dz, hh, best;
        longint q, k, a, bh, bz, b, c, a2, d, s, t0, t1;
        hit_t   h;
        ox = r.ox; oy = r.oy; oz = r.oz;
        dx = r.dx; dy = r.dy; dz = r.dz;
        hh = longint'(r.hgt) >>> 1;
        best = longint'(r.far);
        h.found = 1'b0;
        if (hh != 0) begin
            q  = fx_div(longint'(r.rad), hh);
            k  = fx_mul(q, q);
            a  = fx_add(fx_add(fx_mul(dx, dx), fx_mul(dy, dy)), -fx_mul(fx_mul(dz, dz), k));
            bh = fx_add(fx_mul(ox, dx), fx_mul(oy, dy));
            bz = fx_mul(fx_mul(oz, dz), k);
            b  = fx_add(fx_add(bh, bh), -fx_add(bz, bz));
            c  = fx_add(fx_add(fx_mul(ox, ox), fx_mul(oy, oy)), -fx_mul(fx_mul(oz, oz), k));
            a2 = fx_add(a, a);
            d  = fx_add(fx_mul(b, b), -fx_mul(fx_add(a2, a2), c));
            if (d >= 0 && a != 0) begin
                s = fx_sqrt(d);
                if (s != 0) begin
                    t0 = fx_div(fx_add(-b, s), a2);
                    t1 = fx_div(fx_add(-b, -s), a2);
                    if (on_coat(t0, oz, dz, hh) && t0 < best) begin
                        best = t0;
                        h.found = 1'b1;
                    end
                    if (on_coat(t1, oz, dz, hh) && t1 < best) begin
                        best = t1;
                        h.found = 1'b1;
                    end
                end
            end
        end
        h.distance = best[30:0];
        return h;
    endfunction

    function automatic ray_t make_ray(longint ox, longint oy, longint oz, longint dx,
                                      longint dy, longint dz, longint rad, longint hgt,
                                      longint far);
        ray_t r;
        r.ox = ox[31:0]; r.oy = oy[31:0]; r.oz = oz[31:0];
        r.dx = dx[31:0]; r.dy = dy[31:0]; r.dz = dz[31:0];
        r.rad = rad[30:0]; r.hgt = hgt[30:0]; r.far = far[30:0];
        return r;
    endfunction

    function automatic longint small_signed(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly rays aimed near a modest cone so that the coat is actually reached.
    function automatic ray_t random_ray();
        ray_t r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 20) begin
            r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
            r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
            r.rad = 31'($urandom); r.hgt = 31'($urandom); r.far = 31'($urandom);
        end else begin
            r.rad = 31'($urandom_range(32'h0000_1000, 32'h0010_0000));
            r.hgt = 31'($urandom_range(32'h0000_4000, 32'h0020_0000));
            r.ox  = 32'(small_signed(32'h0018_0000));
            r.oy  = 32'(small_signed(32'h0018_0000));
            r.oz  = 32'(small_signed(32'h0012_0000));
            r.dx  = 32'(small_signed(32'h0004_0000));
            r.dy  = 32'(small_signed(32'h0004_0000));
            r.dz  = 32'(small_signed(32'h0002_0000));
            r.far = (pick < 90) ? 31'h7FFF_FFFF : 31'($urandom_range(32'h0008_0000));
        end
        return r;
    endfunction

    // Offers one word and returns once it has been accepted; valid stays high afterward.
    task automatic send_ray(ray_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_origin_x    <= r.ox;
        i_origin_y    <= r.oy;
        i_origin_z    <= r.oz;
        i_dir_x       <= r.dx;
        i_dir_y       <= r.dy;
        i_dir_z       <= r.dz;
        i_cone_radius <= r.rad;
        i_cone_height <= r.hgt;
        i_far_limit   <= r.far;
        do @(posedge i_clk); while (!o_in_ready);
        hits_pending.push_back(cone_hit(r));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            i_out_ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            hold_req = 1'b0;
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        hit_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (hits_pending.size() == 0) begin
                $display("%0t: unexpected word: distance %h found %b", $time,
                         o_hit_distance, o_hit_found);
                fail_count++;
            end else begin
                want = hits_pending.pop_front();
                if (o_hit_distance !== want.distance) begin
                    $display("%0t: hit_distance expected %h actual %h", $time,
                             want.distance, o_hit_distance);
                    fail_count++;
                end
                if (o_hit_found !== want.found) begin
                    $display("%0t: hit_found expected %b actual %b", $time,
                             want.found, o_hit_found);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        longint one;
        one = 64'sd65536;
        // Zero half height, both raw encodings.
        send_ray(make_ray(5*one, 0, 2*one, -one, 0, 0, 4*one, 0, 100*one));
        send_ray(make_ray(5*one, 0, 2*one, -one, 0, 0, 4*one, 1, 100*one));
        // Plain hit on the coat at t = 3, then the same with two closer far limits.
        send_ray(make_ray(5*one, 0, 2*one, -one, 0, 0, 4*one, 8*one, 100*one));
        send_ray(make_ray(5*one, 0, 2*one, -one, 0, 0, 4*one, 8*one, one));
        send_ray(make_ray(5*one, 0, 2*one, -one, 0, 0, 4*one, 8*one, 3*one));
        // Ray passing well beside the cone: its real roots lie outside the coat span.
        send_ray(make_ray(5*one, 9*one, 2*one, 0, 0, one, 4*one, 8*one, 100*one));
        // Null direction gives a zero leading coefficient.
        send_ray(make_ray(5*one, 0, 2*one, 0, 0, 0, 4*one, 8*one, 100*one));
        // Grazing the coat, and running parallel to it.
        send_ray(make_ray(2*one, -5*one, 2*one, 0, one, 0, 4*one, 8*one, 100*one));
        send_ray(make_ray(one, 0, 0, one, 0, one, 4*one, 8*one, 100*one));
        // Root behind the origin and root outside the coat span.
        send_ray(make_ray(5*one, 0, 2*one, one, 0, 0, 4*one, 8*one, 100*one));
        send_ray(make_ray(5*one, 0, 9*one, -one, 0, 0, 4*one, 8*one, 100*one));
        // Zero radius, and from inside the cone, starting on the axis.
        send_ray(make_ray(5*one, 0, 2*one, -one, 0, 0, 0, 8*one, 100*one));
        send_ray(make_ray(0, 0, one, one, 0, 0, 4*one, 8*one, 100*one));
        // Field extremes.
        send_ray(make_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                          -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                          0, 2, 0));
        send_ray(make_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                          64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                          64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
        send_ray(make_ray(-64'sd2147483648, 64'sd2147483647, 0, 64'sd2147483647,
                          -64'sd2147483648, 1, 64'sd2147483647, 2, 64'sd2147483647));
        send_ray(make_ray(1, -1, 1, -1, 1, -1, 1, 64'sd2147483647, 1));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_ray(random_ray());
    endtask

    // The receiver stops for a long stretch while words keep coming; the pipeline
    // holds a little over two hundred words, so the input stalls well before the end.
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random(250);
    endtask

    initial begin
        fail_count    = 0;
        quiet_cycles  = 0;
        hold_req      = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 81;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_ready   = 1'b0;
        i_origin_x    = '0;
        i_origin_y    = '0;
        i_origin_z    = '0;
        i_dir_x       = '0;
        i_dir_y       = '0;
        i_dir_z       = '0;
        i_cone_radius = '0;
        i_cone_height = '0;
        i_far_limit   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(80);
        send_idle_pct = 81;
        recv_idle_pct = 7;
        test_random(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(80);
        test_backpressure();
        i_in_valid <= 1'b0;

        while (hits_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
